>>> rtl/ipsd_pkg.sv
`timescale 1ns / 1ps

package ipsd_pkg;

  // phase and duty resolution
  localparam int ANGLE_BITS = 16;
  localparam int DUTY_BITS  = 16;

  // quarter-wave sine polynomial, Q16
  localparam int SIN_W   = 18;
  localparam int SIN_STG = 5;
  localparam int SIN_A   = 102944;
  localparam int SIN_B   = 42334;
  localparam int SIN_C   = 5223;
  localparam int SIN_D   = 307;

  // restoring divider cell: remainder/divisor and quotient widths
  localparam int REM_W = 40;
  localparam int QUO_W = 43;

endpackage

>>> rtl/ipsd_sine.sv
`timescale 1ns / 1ps

module ipsd_sine (
  input  logic                                clk_i,
  input  logic [ipsd_pkg::SIN_STG-1:0]        en_i,
  input  logic [31:0]                         phase_i,
  output logic signed [ipsd_pkg::SIN_W-1:0]   sin_o
);

  logic [1:0]  quad_q [ipsd_pkg::SIN_STG-1];
  logic [16:0] x_q    [ipsd_pkg::SIN_STG-1];
  logic [16:0] x2_q   [ipsd_pkg::SIN_STG-2];
  logic [12:0] t1_q;
  logic [15:0] t2_q;
  logic [16:0] t3_q;
  logic signed [ipsd_pkg::SIN_W-1:0] sin_q;

  logic [16:0] x_d;
  logic [33:0] sq_d;
  logic [25:0] p1_d;
  logic [29:0] p2_d;
  logic [32:0] p3_d;
  logic [33:0] p4_d;
  logic [17:0] s_d;
  logic [16:0] sc_d;

  always_comb begin
    // mirror the fraction in odd quadrants
    x_d  = phase_i[30] ? (17'd65536 - {1'b0, phase_i[29:14]}) : {1'b0, phase_i[29:14]};
    sq_d = 34'(x_d) * 34'(x_d);
    p1_d = 26'(x2_q[0]) * 26'(ipsd_pkg::SIN_D);
    p2_d = 30'(x2_q[1]) * 30'(t1_q);
    p3_d = 33'(x2_q[2]) * 33'(t2_q);
    p4_d = 34'(x_q[3]) * 34'(t3_q);
    s_d  = p4_d[33:16];
    sc_d = (s_d > 18'd65536) ? 17'd65536 : s_d[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad_q[0] <= phase_i[31:30];
      x_q[0]    <= x_d;
      x2_q[0]   <= sq_d[32:16];
    end
    if (en_i[1]) begin
      quad_q[1] <= quad_q[0];
      x_q[1]    <= x_q[0];
      x2_q[1]   <= x2_q[0];
      t1_q      <= 13'(ipsd_pkg::SIN_C) - 13'(p1_d[25:16]);
    end
    if (en_i[2]) begin
      quad_q[2] <= quad_q[1];
      x_q[2]    <= x_q[1];
      x2_q[2]   <= x2_q[1];
      t2_q      <= 16'(ipsd_pkg::SIN_B) - 16'(p2_d[29:16]);
    end
    if (en_i[3]) begin
      quad_q[3] <= quad_q[2];
      x_q[3]    <= x_q[2];
      t3_q      <= 17'(ipsd_pkg::SIN_A) - p3_d[32:16];
    end
    if (en_i[4]) begin
      sin_q     <= quad_q[3][1] ? -ipsd_pkg::SIN_W'(signed'({1'b0, sc_d}))
                                :  ipsd_pkg::SIN_W'(signed'({1'b0, sc_d}));
    end
  end

  assign sin_o = sin_q;

endmodule

>>> rtl/ipsd_div_cell.sv
`timescale 1ns / 1ps

module ipsd_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ipsd_pkg::REM_W-1:0]   rem_i,
  input  logic                         bit_i,
  input  logic [ipsd_pkg::REM_W-1:0]   div_i,
  input  logic [ipsd_pkg::QUO_W-1:0]   quo_i,
  output logic [ipsd_pkg::REM_W-1:0]   rem_o,
  output logic [ipsd_pkg::QUO_W-1:0]   quo_o
);

  logic [ipsd_pkg::REM_W:0]   cand_d;
  logic [ipsd_pkg::REM_W+1:0] diff_d;
  logic                       ge_d;
  logic [ipsd_pkg::REM_W-1:0] rem_d, rem_q;
  logic [ipsd_pkg::QUO_W-1:0] quo_d, quo_q;

  always_comb begin
    cand_d = {rem_i, bit_i};
    diff_d = {1'b0, cand_d} - {2'b00, div_i};
    ge_d   = !diff_d[ipsd_pkg::REM_W+1];
    rem_d  = ge_d ? diff_d[ipsd_pkg::REM_W-1:0] : cand_d[ipsd_pkg::REM_W-1:0];
    quo_d  = {quo_i[ipsd_pkg::QUO_W-2:0], ge_d};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

>>> rtl/inverse_park_svpwm_duty.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   volt_q_i, volt_d_i, elec_angle_i
// out       output     out_valid_o / out_ready_i duty_a_o, duty_b_o, duty_c_o, sector_number_o
// cfg       input      cfg_we_i                  cfg_wdata_i (bus_voltage_max)
//
// One word per cycle sustained while the output is not stalled.
// Most of the pipeline is the two rows of restoring divider cells (43 + 25 cells).
// Reset clears the stage valid flags and loads a bus voltage of 12000.
// A stalled output only holds the stages behind it up to the first empty stage.

module inverse_park_svpwm_duty (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [14:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [15:0]                volt_q_i,
  input  logic signed [15:0]                volt_d_i,
  input  logic [15:0]                       elec_angle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ipsd_pkg::DUTY_BITS-1:0]    duty_a_o,
  output logic [ipsd_pkg::DUTY_BITS-1:0]    duty_b_o,
  output logic [ipsd_pkg::DUTY_BITS-1:0]    duty_c_o,
  output logic [2:0]                        sector_number_o
);

  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6
  } sector_e;

  localparam int VW      = 16;
  localparam int PW      = 34;
  localparam int KW      = 52;
  localparam int MAG_SH  = 8;
  localparam int MW      = KW - 1 - MAG_SH;
  localparam int SW      = 39;
  localparam int SUMW    = SW + 1;
  localparam int NSH     = MW + 1 - SW;
  localparam int TFRAC   = 24;
  localparam int TW      = TFRAC + 1;
  localparam int DB      = ipsd_pkg::DUTY_BITS;
  localparam int PRW     = TW + DB;
  localparam int SIN_STG = ipsd_pkg::SIN_STG;
  localparam int D1_N    = MW;
  localparam int D2_N    = TW;

  localparam int ST_IN   = 0;
  localparam int ST_PROD = ST_IN + SIN_STG + 1;
  localparam int ST_SUM  = ST_PROD + 1;
  localparam int ST_MUL  = ST_SUM + 1;
  localparam int ST_K    = ST_MUL + 1;
  localparam int ST_SEC  = ST_K + 1;
  localparam int ST_D1   = ST_SEC + 1;
  localparam int ST_NORM = ST_D1 + D1_N;
  localparam int ST_D2   = ST_NORM + 1;
  localparam int ST_TIME = ST_D2 + D2_N;
  localparam int ST_DUTY = ST_TIME + 1;
  localparam int ST_OUT  = ST_DUTY + 1;
  localparam int NSTG    = ST_OUT + 1;

  localparam int ANG_SH = 32 - ipsd_pkg::ANGLE_BITS;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ipsd_pkg::ANGLE_BITS) - 64'd1);
  localparam logic [31:0] QUARTER  = 32'h4000_0000;
  localparam logic [14:0] BVM_RST  = 15'd12000;
  localparam logic signed [KW-1:0] S3_K = KW'(113512);
  localparam logic [TW-1:0] T_ONE  = TW'(1) << TFRAC;
  localparam logic [DB-1:0] FULL   = {DB{1'b1}};
  localparam logic [DB-1:0] HALF   = DB'(1) << (DB - 1);
  localparam logic [PRW-1:0] RND   = PRW'(1) << (TFRAC - 1);

  typedef struct packed {
    logic            ovm;
    logic [SUMW-1:0] sum;
    logic [TW-1:0]   txo;
    logic [TW-1:0]   tyo;
  } nside_t;

  function automatic logic [MW-1:0] mag_hi(input logic signed [KW-1:0] v);
    logic [KW-1:0] a;
    a = v[KW-1] ? KW'(-v) : KW'(v);
    return a[KW-2:MAG_SH];
  endfunction

  function automatic logic [TW-1:0] to_half(input logic [TW-1:0] t);
    logic [TW:0]   s;
    logic [TW-1:0] d;
    s = {1'b0, t} + {1'b0, T_ONE};
    d = s[TW:1];
    return (d > T_ONE) ? T_ONE : d;
  endfunction

  // ---------------- control ----------------
  logic [NSTG-1:0] v_q, v_d, en;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&v_q[NSTG-1:k]);
  end

  assign v_d = {v_q[NSTG-2:0], in_valid_i};

  logic [14:0] bvm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      bvm_q <= BVM_RST;
    end else begin
      v_q <= (v_d & en) | (v_q & ~en);
      if (cfg_we_i) begin
        // zero bus voltage behaves as one
        bvm_q <= (cfg_wdata_i == '0) ? 15'd1 : cfg_wdata_i;
      end
    end
  end

  assign in_ready_o  = en[ST_IN];
  assign out_valid_o = v_q[NSTG-1];

  // ---------------- datapath ----------------
  logic signed [VW-1:0] vq_q [SIN_STG+1];
  logic signed [VW-1:0] vd_q [SIN_STG+1];
  logic [31:0] ph_q, ph_d;
  logic signed [ipsd_pkg::SIN_W-1:0] sn, cs;

  assign ph_d = (32'(elec_angle_i) & ANG_MASK) << ANG_SH;

  ipsd_sine u_sin (
    .clk_i   (clk_i),
    .en_i    (en[ST_IN+SIN_STG:ST_IN+1]),
    .phase_i (ph_q),
    .sin_o   (sn)
  );

  ipsd_sine u_cos (
    .clk_i   (clk_i),
    .en_i    (en[ST_IN+SIN_STG:ST_IN+1]),
    .phase_i (ph_q + QUARTER),
    .sin_o   (cs)
  );

  logic signed [PW-1:0] pdc_q, pqs_q, pqc_q, pds_q, ua_q, ub_q;
  logic signed [KW-1:0] s3ub_q, ua3_q, kx_q, ky_q, kz_q;

  logic kx_neg, ky_neg, kz_neg, kx_pos, ky_pos, kz_pos;
  sector_e sec_d;
  logic signed [KW-1:0] selx, sely;

  always_comb begin
    kx_neg = kx_q[KW-1];
    ky_neg = ky_q[KW-1];
    kz_neg = kz_q[KW-1];
    kx_pos = !kx_neg && (kx_q != '0);
    ky_pos = !ky_neg && (ky_q != '0);
    kz_pos = !kz_neg && (kz_q != '0);
    sec_d  = SEC_NONE;
    selx   = '0;
    sely   = '0;
    // boundaries inclusive, first match wins
    if (!kx_neg && ky_pos) begin
      sec_d = SEC_1; selx = ky_q; sely = kx_q;
    end else if (!ky_pos && kz_pos) begin
      sec_d = SEC_2; selx = ky_q; sely = kz_q;
    end else if (!kz_pos && kx_pos) begin
      sec_d = SEC_3; selx = kx_q; sely = kz_q;
    end else if (!kx_pos && ky_neg) begin
      sec_d = SEC_4; selx = kx_q; sely = ky_q;
    end else if (!ky_neg && kz_neg) begin
      sec_d = SEC_5; selx = kz_q; sely = ky_q;
    end else if (!kz_neg && kx_neg) begin
      sec_d = SEC_6; selx = kz_q; sely = kx_q;
    end
  end

  sector_e          sec_q [ST_SEC:NSTG-1];
  logic [MW-1:0]    mx_q  [D1_N];
  logic [MW-1:0]    my_q  [D1_N];

  // divide by the bus voltage: one quotient bit per cell
  logic [ipsd_pkg::REM_W-1:0] rem_x1 [D1_N];
  logic [ipsd_pkg::REM_W-1:0] rem_y1 [D1_N];
  logic [ipsd_pkg::QUO_W-1:0] quo_x1 [D1_N];
  logic [ipsd_pkg::QUO_W-1:0] quo_y1 [D1_N];

  for (genvar j = 0; j < D1_N; j++) begin : g_d1
    logic [ipsd_pkg::REM_W-1:0] rx_in, ry_in;
    logic [ipsd_pkg::QUO_W-1:0] qx_in, qy_in;
    if (j == 0) begin : g_first
      assign rx_in = '0;
      assign ry_in = '0;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign rx_in = rem_x1[j-1];
      assign ry_in = rem_y1[j-1];
      assign qx_in = quo_x1[j-1];
      assign qy_in = quo_y1[j-1];
    end
    ipsd_div_cell u_cx (
      .clk_i (clk_i),
      .en_i  (en[ST_D1+j]),
      .rem_i (rx_in),
      .bit_i (mx_q[j][MW-1-j]),
      .div_i (ipsd_pkg::REM_W'(bvm_q)),
      .quo_i (qx_in),
      .rem_o (rem_x1[j]),
      .quo_o (quo_x1[j])
    );
    ipsd_div_cell u_cy (
      .clk_i (clk_i),
      .en_i  (en[ST_D1+j]),
      .rem_i (ry_in),
      .bit_i (my_q[j][MW-1-j]),
      .div_i (ipsd_pkg::REM_W'(bvm_q)),
      .quo_i (qy_in),
      .rem_o (rem_y1[j]),
      .quo_o (quo_y1[j])
    );
  end

  // overmodulation: bring the sum under 2^39, then divide each by it
  logic [MW-1:0] tx1, ty1;
  logic [MW:0]   sums [NSH+1];
  logic [2:0]    sh_sel;
  nside_t        ns_d;
  logic [SW-1:0] nx_d, ny_d, nx_q, ny_q;

  always_comb begin
    tx1    = quo_x1[D1_N-1][MW-1:0];
    ty1    = quo_y1[D1_N-1][MW-1:0];
    sh_sel = 3'(NSH);
    for (int s = 0; s <= NSH; s++) begin
      sums[s] = {1'b0, tx1 >> s} + {1'b0, ty1 >> s};
    end
    for (int s = NSH; s >= 0; s--) begin
      if (sums[s][MW:SW] == '0) sh_sel = 3'(s);
    end
    nx_d       = SW'(tx1 >> sh_sel);
    ny_d       = SW'(ty1 >> sh_sel);
    ns_d.ovm   = sums[0] > (MW+1)'(T_ONE);
    ns_d.sum   = SUMW'(sums[sh_sel]);
    ns_d.txo   = tx1[TW-1:0];
    ns_d.tyo   = ty1[TW-1:0];
  end

  nside_t ns_q [ST_NORM:ST_TIME-1];

  logic [ipsd_pkg::REM_W-1:0] rem_x2 [D2_N];
  logic [ipsd_pkg::REM_W-1:0] rem_y2 [D2_N];
  logic [ipsd_pkg::QUO_W-1:0] quo_x2 [D2_N];
  logic [ipsd_pkg::QUO_W-1:0] quo_y2 [D2_N];

  for (genvar j = 0; j < D2_N; j++) begin : g_d2
    logic [ipsd_pkg::REM_W-1:0] rx_in, ry_in;
    logic [ipsd_pkg::QUO_W-1:0] qx_in, qy_in;
    logic                       bx_in, by_in;
    if (j == 0) begin : g_first
      // first step shifts in the low bit of the dividend itself
      assign rx_in = ipsd_pkg::REM_W'(nx_q >> 1);
      assign ry_in = ipsd_pkg::REM_W'(ny_q >> 1);
      assign bx_in = nx_q[0];
      assign by_in = ny_q[0];
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign rx_in = rem_x2[j-1];
      assign ry_in = rem_y2[j-1];
      assign bx_in = 1'b0;
      assign by_in = 1'b0;
      assign qx_in = quo_x2[j-1];
      assign qy_in = quo_y2[j-1];
    end
    ipsd_div_cell u_cx (
      .clk_i (clk_i),
      .en_i  (en[ST_D2+j]),
      .rem_i (rx_in),
      .bit_i (bx_in),
      .div_i (ns_q[ST_D2+j-1].sum),
      .quo_i (qx_in),
      .rem_o (rem_x2[j]),
      .quo_o (quo_x2[j])
    );
    ipsd_div_cell u_cy (
      .clk_i (clk_i),
      .en_i  (en[ST_D2+j]),
      .rem_i (ry_in),
      .bit_i (by_in),
      .div_i (ns_q[ST_D2+j-1].sum),
      .quo_i (qy_in),
      .rem_o (rem_y2[j]),
      .quo_o (quo_y2[j])
    );
  end

  // active and zero times
  logic [TW-1:0] tx2_d, ty2_d, tz_d;
  logic [TW:0]   tsum_d, tzf_d;
  logic [TW-1:0] tx_q, ty_q, tz_q;

  always_comb begin
    tx2_d  = ns_q[ST_TIME-1].ovm ? quo_x2[D2_N-1][TW-1:0] : ns_q[ST_TIME-1].txo;
    ty2_d  = ns_q[ST_TIME-1].ovm ? quo_y2[D2_N-1][TW-1:0] : ns_q[ST_TIME-1].tyo;
    tsum_d = {1'b0, tx2_d} + {1'b0, ty2_d};
    tzf_d  = {1'b0, T_ONE} - tsum_d;
    tz_d   = tzf_d[TW:1];
  end

  logic [TW-1:0] mid_d, hi_d, ta_d, tb_d, tc_d;
  logic [TW-1:0] da_q, db_q, dc_q;

  always_comb begin
    mid_d = tz_q + ty_q;
    hi_d  = mid_d + tx_q;
    unique case (sec_q[ST_DUTY-1])
      SEC_1:   begin ta_d = hi_d;  tb_d = mid_d; tc_d = tz_q;  end
      SEC_2:   begin ta_d = mid_d; tb_d = hi_d;  tc_d = tz_q;  end
      SEC_3:   begin ta_d = tz_q;  tb_d = hi_d;  tc_d = mid_d; end
      SEC_4:   begin ta_d = tz_q;  tb_d = mid_d; tc_d = hi_d;  end
      SEC_5:   begin ta_d = mid_d; tb_d = tz_q;  tc_d = hi_d;  end
      default: begin ta_d = hi_d;  tb_d = tz_q;  tc_d = mid_d; end
    endcase
  end

  logic [PRW-1:0] pa_d, pb_d, pc_d;
  logic [DB-1:0]  duty_a_q, duty_b_q, duty_c_q;

  assign pa_d = PRW'(da_q) * PRW'(FULL) + RND;
  assign pb_d = PRW'(db_q) * PRW'(FULL) + RND;
  assign pc_d = PRW'(dc_q) * PRW'(FULL) + RND;

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      vq_q[0] <= volt_q_i;
      vd_q[0] <= volt_d_i;
      ph_q    <= ph_d;
    end
    for (int i = 1; i <= SIN_STG; i++) begin
      if (en[ST_IN+i]) begin
        vq_q[i] <= vq_q[i-1];
        vd_q[i] <= vd_q[i-1];
      end
    end
    if (en[ST_PROD]) begin
      pdc_q <= PW'(vd_q[SIN_STG]) * PW'(cs);
      pqs_q <= PW'(vq_q[SIN_STG]) * PW'(sn);
      pqc_q <= PW'(vq_q[SIN_STG]) * PW'(cs);
      pds_q <= PW'(vd_q[SIN_STG]) * PW'(sn);
    end
    if (en[ST_SUM]) begin
      ua_q <= pdc_q - pqs_q;
      ub_q <= pqc_q + pds_q;
    end
    if (en[ST_MUL]) begin
      s3ub_q <= KW'(ub_q) * S3_K;
      ua3_q  <= (KW'(ua_q) <<< 16) + (KW'(ua_q) <<< 17);
    end
    if (en[ST_K]) begin
      kx_q <= s3ub_q <<< 1;
      ky_q <= ua3_q - s3ub_q;
      kz_q <= ua3_q + s3ub_q;
    end
    if (en[ST_SEC]) begin
      sec_q[ST_SEC] <= sec_d;
      mx_q[0]       <= mag_hi(selx);
      my_q[0]       <= mag_hi(sely);
    end
    for (int i = ST_SEC + 1; i < NSTG; i++) begin
      if (en[i]) sec_q[i] <= sec_q[i-1];
    end
    for (int j = 1; j < D1_N; j++) begin
      if (en[ST_SEC+j]) begin
        mx_q[j] <= mx_q[j-1];
        my_q[j] <= my_q[j-1];
      end
    end
    if (en[ST_NORM]) begin
      nx_q          <= nx_d;
      ny_q          <= ny_d;
      ns_q[ST_NORM] <= ns_d;
    end
    for (int i = ST_NORM + 1; i < ST_TIME; i++) begin
      if (en[i]) ns_q[i] <= ns_q[i-1];
    end
    if (en[ST_TIME]) begin
      tx_q <= tx2_d;
      ty_q <= ty2_d;
      tz_q <= tz_d;
    end
    if (en[ST_DUTY]) begin
      da_q <= to_half(ta_d);
      db_q <= to_half(tb_d);
      dc_q <= to_half(tc_d);
    end
    if (en[ST_OUT]) begin
      if (sec_q[ST_OUT-1] == SEC_NONE) begin
        duty_a_q <= HALF;
        duty_b_q <= HALF;
        duty_c_q <= HALF;
      end else begin
        duty_a_q <= pa_d[TFRAC +: DB];
        duty_b_q <= pb_d[TFRAC +: DB];
        duty_c_q <= pc_d[TFRAC +: DB];
      end
    end
  end

  assign duty_a_o        = duty_a_q;
  assign duty_b_o        = duty_b_q;
  assign duty_c_o        = duty_c_q;
  assign sector_number_o = sec_q[NSTG-1];

endmodule

>>> test/svpwm_duty_checker.sv
`timescale 1ns / 1ps

module svpwm_duty_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [14:0]                    cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic signed [15:0]             volt_q_i,
  input  logic signed [15:0]             volt_d_i,
  input  logic [15:0]                    elec_angle_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [ipsd_pkg::DUTY_BITS-1:0] duty_a_i,
  input  logic [ipsd_pkg::DUTY_BITS-1:0] duty_b_i,
  input  logic [ipsd_pkg::DUTY_BITS-1:0] duty_c_i,
  input  logic [2:0]                     sector_number_i,
  output int                             fail_cnt_o,
  output int                             pending_o
);
  localparam int DUTY_BITS  = ipsd_pkg::DUTY_BITS;
  localparam int ANGLE_BITS = ipsd_pkg::ANGLE_BITS;

  typedef enum logic [2:0] {
    SEC_ZERO, SEC_1, SEC_2, SEC_3, SEC_4, SEC_5, SEC_6
  } sector_e;

  typedef struct {
    logic [DUTY_BITS-1:0] da;
    logic [DUTY_BITS-1:0] db;
    logic [DUTY_BITS-1:0] dc;
    logic [2:0]           sec;
  } duty_word_t;

  localparam longint unsigned T_FULL = 64'd1 << 24;
  localparam longint ROOT3 = 113512;
  localparam longint unsigned POLY_A = 102944;
  localparam longint unsigned POLY_B = 42334;
  localparam longint unsigned POLY_C = 5223;
  localparam longint unsigned POLY_D = 307;

  logic [14:0] bus_volt;
  duty_word_t  duty_q[$];

  function automatic longint sine_q16(logic [31:0] ph);
    longint unsigned x, x2, t, s;
    logic [1:0] quad;
    quad = ph[31:30];
    x = ph[29:14];
    if (quad[0]) x = 65536 - x;
    x2 = (x * x) >> 16;
    t = (x2 * POLY_D) >> 16;
    t = POLY_C - t;
    t = (x2 * t) >> 16;
    t = POLY_B - t;
    t = (x2 * t) >> 16;
    t = POLY_A - t;
    s = (x * t) >> 16;
    if (s > 65536) s = 65536;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic [DUTY_BITS-1:0] time_to_duty(longint unsigned t);
    longint unsigned d, full;
    full = (64'd1 << DUTY_BITS) - 1;
    d = (t + T_FULL) >> 1;
    if (d > T_FULL) d = T_FULL;
    return DUTY_BITS'(((d * full) + (64'd1 << 23)) >> 24);
  endfunction

  function automatic duty_word_t svpwm_duty(logic signed [15:0] q, logic signed [15:0] d,
                                            logic [15:0] ang);
    duty_word_t w;
    longint vq, vd, sn, cs, ua, ub, kx, ky, kz;
    longint unsigned mx, my, tx, ty, tz, lo, mid, hi, dv, sum;
    logic [31:0] ph;
    sector_e sec;
    vq = q;
    vd = d;
    ph = 32'(ang[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    sn = sine_q16(ph);
    cs = sine_q16(ph + 32'h4000_0000);
    ua = vd * cs - vq * sn;
    ub = vq * cs + vd * sn;
    kx = 2 * ROOT3 * ub;
    ky = 196608 * ua - ROOT3 * ub;
    kz = 196608 * ua + ROOT3 * ub;
    if (kx >= 0 && ky > 0) begin
      sec = SEC_1; mx = mag(ky); my = mag(kx);
    end else if (ky <= 0 && kz > 0) begin
      sec = SEC_2; mx = mag(ky); my = mag(kz);
    end else if (kz <= 0 && kx > 0) begin
      sec = SEC_3; mx = mag(kx); my = mag(kz);
    end else if (kx <= 0 && ky < 0) begin
      sec = SEC_4; mx = mag(kx); my = mag(ky);
    end else if (ky >= 0 && kz < 0) begin
      sec = SEC_5; mx = mag(kz); my = mag(ky);
    end else if (kz >= 0 && kx < 0) begin
      sec = SEC_6; mx = mag(kz); my = mag(kx);
    end else begin
      sec = SEC_ZERO; mx = 0; my = 0;
    end
    if (sec == SEC_ZERO) begin
      w.da = DUTY_BITS'(1) << (DUTY_BITS - 1);
      w.db = w.da;
      w.dc = w.da;
      w.sec = SEC_ZERO;
      return w;
    end
    dv = ((bus_volt == 0) ? 64'd1 : 64'(bus_volt)) * 256;
    tx = mx / dv;
    ty = my / dv;
    // overmodulation: rescale both by their sum once shifted under 2^39
    if (tx + ty > T_FULL) begin
      while (tx + ty >= (64'd1 << 39)) begin
        tx = tx >> 1;
        ty = ty >> 1;
      end
      sum = tx + ty;
      tx = (tx << 24) / sum;
      ty = (ty << 24) / sum;
    end
    tz = (T_FULL - tx - ty) >> 1;
    lo = tz;
    mid = tz + ty;
    hi = tz + ty + tx;
    case (sec)
      SEC_1: begin w.da = time_to_duty(hi); w.db = time_to_duty(mid); w.dc = time_to_duty(lo); end
      SEC_2: begin w.da = time_to_duty(mid); w.db = time_to_duty(hi); w.dc = time_to_duty(lo); end
      SEC_3: begin w.da = time_to_duty(lo); w.db = time_to_duty(hi); w.dc = time_to_duty(mid); end
      SEC_4: begin w.da = time_to_duty(lo); w.db = time_to_duty(mid); w.dc = time_to_duty(hi); end
      SEC_5: begin w.da = time_to_duty(mid); w.db = time_to_duty(lo); w.dc = time_to_duty(hi); end
      default: begin
        w.da = time_to_duty(hi); w.db = time_to_duty(lo); w.dc = time_to_duty(mid);
      end
    endcase
    w.sec = sec;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_word_t exp_w;
    if (!rst_ni) begin
      bus_volt <= 15'd12000;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) bus_volt <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        duty_q.push_back(svpwm_duty(volt_q_i, volt_d_i, elec_angle_i));
      if (out_valid_i && out_ready_i) begin
        if (duty_q.size() == 0) begin
          $error("unexpected output word");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_w = duty_q.pop_front();
          if (duty_a_i !== exp_w.da || duty_b_i !== exp_w.db || duty_c_i !== exp_w.dc ||
              sector_number_i !== exp_w.sec)
            fail_cnt_o <= fail_cnt_o + 1;
          if (duty_a_i !== exp_w.da)
            $error("duty_a expected %0d actual %0d", exp_w.da, duty_a_i);
          if (duty_b_i !== exp_w.db)
            $error("duty_b expected %0d actual %0d", exp_w.db, duty_b_i);
          if (duty_c_i !== exp_w.dc)
            $error("duty_c expected %0d actual %0d", exp_w.dc, duty_c_i);
          if (sector_number_i !== exp_w.sec)
            $error("sector_number expected %0d actual %0d", exp_w.sec, sector_number_i);
        end
      end
      pending_o <= duty_q.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] volt_q_i = '0;
  logic signed [15:0] volt_d_i = '0;
  logic [15:0] elec_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ipsd_pkg::DUTY_BITS-1:0] duty_a_o, duty_b_o, duty_c_o;
  logic [2:0] sector_number_o;

  int fail_cnt, pending;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  logic [14:0] bus_now = 15'd12000;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  inverse_park_svpwm_duty dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .volt_q_i, .volt_d_i, .elec_angle_i,
    .out_valid_o, .out_ready_i, .duty_a_o, .duty_b_o, .duty_c_o, .sector_number_o
  );

  svpwm_duty_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .volt_q_i, .volt_d_i, .elec_angle_i,
    .out_valid_i(out_valid_o), .out_ready_i, .duty_a_i(duty_a_o), .duty_b_i(duty_b_o),
    .duty_c_i(duty_c_o), .sector_number_i(sector_number_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver: random stalls, or a counted long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_word(logic signed [15:0] q, logic signed [15:0] d, logic [15:0] a);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    volt_q_i <= q;
    volt_d_i <= d;
    elec_angle_i <= a;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic set_bus(logic [14:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    bus_now = (v == 0) ? 15'd1 : v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_words(int n);
    logic signed [15:0] q, d;
    int m;
    repeat (n) begin
      if ($urandom_range(1)) begin
        q = 16'($urandom);
        d = 16'($urandom);
      end else begin
        // mostly within the linear range for the current bus
        m = $urandom_range(bus_now);
        q = 16'($urandom_range(m));
        d = 16'($urandom_range(m));
        if ($urandom_range(1)) q = -q;
        if ($urandom_range(1)) d = -d;
      end
      send_word(q, d, 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] angs[5];
    logic [14:0] buses[4];
    int idles[4], stalls[4];
    angs = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
    buses = '{15'd32767, 15'd1, 15'd0, 15'd20000};
    idles = '{0, 69, 0, 32};
    stalls = '{0, 0, 69, 32};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vector, sector boundaries and extremes at reset bus voltage
    send_word(16'sd0, 16'sd0, 16'd1234);
    foreach (angs[i]) begin
      send_word(16'sd0, 16'sd4000, angs[i]);
      send_word(16'sh7FFF, 16'sh8000, angs[i]);
      send_word(16'sh8000, 16'sh7FFF, angs[i]);
      send_word(16'sd6000, 16'sd0, angs[i]);
    end
    send_word(16'sh8000, 16'sh8000, 16'd5461);

    for (int p = 0; p < 4; p++) begin
      set_bus(buses[p]);
      send_idle = idles[p];
      recv_stall = stalls[p];
      if (p == 0) hold_cycles <= 400;
      random_words(200);
    end
    set_bus(15'($urandom_range(32767)));
    send_idle = 20;
    recv_stall = 20;
    random_words(50);
    in_valid_i <= 1'b0;
    recv_stall = 0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("PASS inverse_park_svpwm_duty");
    else
      $display("FAIL inverse_park_svpwm_duty");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL inverse_park_svpwm_duty");
    $finish;
  end

endmodule

>>> files.f
rtl/ipsd_pkg.sv
rtl/ipsd_sine.sv
rtl/ipsd_div_cell.sv
rtl/inverse_park_svpwm_duty.sv
test/svpwm_duty_checker.sv
test/tb.sv
